FILE: rtl/signed_binary_to_ascii_decimal_macros.svh
// assertion macros used by the signed binary to ascii decimal rtl (sbad_ctrl)
// users need i_clk and i_rst_n in scope at the point of use
`ifndef SIGNED_BINARY_TO_ASCII_DECIMAL_MACROS_SVH
`define SIGNED_BINARY_TO_ASCII_DECIMAL_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBAD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sbad assertion failed");

// next-cycle implication, checked outside reset
`define SBAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sbad assertion failed");

`endif

FILE: rtl/sbad_pkg.sv
// types and constants for the signed binary to ascii decimal converter
// no dependencies
package sbad_pkg;

    localparam int DATA_W   = 32;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int CHAR_W   = 6;
    localparam int CNT_W    = 5;
    localparam logic [CNT_W-1:0] CNT_LAST = 5'd31;
    localparam logic [1:0] ASCII_DIGIT_HI = 2'b11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_dab_ctrl;

endpackage

FILE: rtl/sbad_dabble.sv
// shared shift-and-add-3 unit: one bcd adjust and shift per step
// depends on sbad_pkg
module sbad_dabble import sbad_pkg::*; (
    input  logic                    i_clk,
    input  t_dab_ctrl               i_ctrl,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                    o_neg,
    output logic [BCD_W-1:0]        o_bcd
);

    logic [DATA_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic              r_neg, n_neg;
    logic [BCD_W-1:0]  adj;
    logic [DATA_W-1:0] mag;

    always_comb begin
        mag = i_value[DATA_W-1] ? (~$unsigned(i_value) + {{(DATA_W-1){1'b0}}, 1'b1})
                                : $unsigned(i_value);
        for (int i = 0; i < DIGITS; i++) begin
            if (r_bcd[4*i +: 4] > 4'd4) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_neg = r_neg;
        if (i_ctrl.load) begin
            n_bin = mag;
            n_bcd = '0;
            n_neg = i_value[DATA_W-1];
        end else if (i_ctrl.step) begin
            n_bin = {r_bin[DATA_W-2:0], 1'b0};
            n_bcd = {adj[BCD_W-2:0], r_bin[DATA_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_neg <= n_neg;
    end

    assign o_neg = r_neg;
    assign o_bcd = r_bcd;

endmodule

FILE: rtl/sbad_ctrl.sv
// sequencer: load, 32 shift steps, hand-off to the output register
// depends on sbad_pkg and the macros header
`include "signed_binary_to_ascii_decimal_macros.svh"
module sbad_ctrl import sbad_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_out_free,
    output logic      o_stall,
    output logic      o_done,
    output t_dab_ctrl o_ctrl
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_stall     = 1'b1;
        o_done      = 1'b0;
        o_ctrl.load = 1'b0;
        o_ctrl.step = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    n_cnt       = '0;
                    n_state     = ST_CONV;
                end
            end
            ST_CONV: begin
                o_ctrl.step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `SBAD_ASSERT_NEXT(a_accept_starts, i_valid && !o_stall, r_state == ST_CONV && r_cnt == '0)
    `SBAD_ASSERT_NEXT(a_last_step_done, r_state == ST_CONV && r_cnt == CNT_LAST, r_state == ST_DONE)
    `SBAD_ASSERT_IMPL(a_done_only_free, o_done, i_out_free && r_state == ST_DONE)
    `SBAD_ASSERT_NEXT(a_done_to_idle, o_done, r_state == ST_IDLE && !o_stall)

endmodule

FILE: rtl/signed_binary_to_ascii_decimal.sv
// Converts one signed 32-bit integer per transaction into a sign flag and ten
// ascii decimal digits of its magnitude, leading zeros shown as '0'; the most
// negative input gives sign 1 and digits 2147483648. A transaction runs from
// accept to the next possible accept: one load, the steps of the shared
// shift-and-add-3 unit (one input bit each), and a move of the result into
// the output register. The output register holds a result
// while o_valid waits on i_stall, so the next input is taken meanwhile; a
// second finished result waits in the converter until the register frees.
// depends on sbad_pkg, sbad_ctrl, sbad_dabble and the macros header
module signed_binary_to_ascii_decimal import sbad_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_is_negative,
    output logic [CHAR_W-1:0]        o_digit_ones,
    output logic [CHAR_W-1:0]        o_digit_tens,
    output logic [CHAR_W-1:0]        o_digit_hundreds,
    output logic [CHAR_W-1:0]        o_digit_thousands,
    output logic [CHAR_W-1:0]        o_digit_ten_thousands,
    output logic [CHAR_W-1:0]        o_digit_hundred_thousands,
    output logic [CHAR_W-1:0]        o_digit_millions,
    output logic [CHAR_W-1:0]        o_digit_ten_millions,
    output logic [CHAR_W-1:0]        o_digit_hundred_millions,
    output logic [CHAR_W-1:0]        o_digit_billions
);

    t_dab_ctrl        dab_ctrl;
    logic             done;
    logic             out_free;
    logic             dab_neg;
    logic [BCD_W-1:0] dab_bcd;
    logic             r_out_valid;
    logic             r_neg;
    logic [BCD_W-1:0] r_bcd;

    assign out_free = !r_out_valid || !i_stall;

    sbad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (out_free),
        .o_stall    (o_stall),
        .o_done     (done),
        .o_ctrl     (dab_ctrl)
    );

    sbad_dabble u_dabble (
        .i_clk   (i_clk),
        .i_ctrl  (dab_ctrl),
        .i_value (i_value),
        .o_neg   (dab_neg),
        .o_bcd   (dab_bcd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_neg <= dab_neg;
            r_bcd <= dab_bcd;
        end
    end

    assign o_valid                   = r_out_valid;
    assign o_is_negative             = r_neg;
    assign o_digit_ones              = {ASCII_DIGIT_HI, r_bcd[3:0]};
    assign o_digit_tens              = {ASCII_DIGIT_HI, r_bcd[7:4]};
    assign o_digit_hundreds          = {ASCII_DIGIT_HI, r_bcd[11:8]};
    assign o_digit_thousands         = {ASCII_DIGIT_HI, r_bcd[15:12]};
    assign o_digit_ten_thousands     = {ASCII_DIGIT_HI, r_bcd[19:16]};
    assign o_digit_hundred_thousands = {ASCII_DIGIT_HI, r_bcd[23:20]};
    assign o_digit_millions          = {ASCII_DIGIT_HI, r_bcd[27:24]};
    assign o_digit_ten_millions      = {ASCII_DIGIT_HI, r_bcd[31:28]};
    assign o_digit_hundred_millions  = {ASCII_DIGIT_HI, r_bcd[35:32]};
    assign o_digit_billions          = {ASCII_DIGIT_HI, r_bcd[39:36]};

endmodule

FILE: bench/tb_top.sv
// self-checking bench for signed_binary_to_ascii_decimal: directed table, then random values
// with random idling and one long output hold; depends on sbad_pkg and the rtl top level
`timescale 1ns / 100ps

module tb_top;
    import sbad_pkg::*;

    localparam int N_RANDOM   = 1500;
    localparam int HOLD_LEN   = 600;
    localparam int WATCH_MAX  = 4000;
    localparam int DRAIN_LEN  = 40;

    typedef struct packed {
        logic                         negative;
        logic [DIGITS-1:0][CHAR_W-1:0] chars;
    } t_decimal;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              typed;
        logic              negative;
        logic [79:0]       text;
    } t_vector;

    localparam int N_VECTORS = 21;
    localparam t_vector VECTORS [N_VECTORS] = '{
        '{32'd0,            1'b1, 1'b0, "0000000000"},
        '{32'h7fff_ffff,    1'b1, 1'b0, "2147483647"},
        '{32'h8000_0000,    1'b1, 1'b1, "2147483648"},
        '{32'hffff_ffff,    1'b1, 1'b1, "0000000001"},
        '{32'd1,            1'b1, 1'b0, "0000000001"},
        '{32'h8000_0001,    1'b1, 1'b1, "2147483647"},
        '{32'd9,            1'b0, 1'b0, 80'h0},
        '{32'd10,           1'b0, 1'b0, 80'h0},
        '{32'd99,           1'b0, 1'b0, 80'h0},
        '{32'd100,          1'b0, 1'b0, 80'h0},
        '{32'd999999999,    1'b0, 1'b0, 80'h0},
        '{32'd1000000000,   1'b1, 1'b0, "1000000000"},
        '{-32'd1000000000,  1'b1, 1'b1, "1000000000"},
        '{32'd1999999999,   1'b0, 1'b0, 80'h0},
        '{32'd2000000000,   1'b0, 1'b0, 80'h0},
        '{32'h5555_5555,    1'b0, 1'b0, 80'h0},
        '{32'haaaa_aaaa,    1'b0, 1'b0, 80'h0},
        '{32'd1234567890,   1'b0, 1'b0, 80'h0},
        '{-32'd10,          1'b0, 1'b0, 80'h0},
        '{32'h0000_ffff,    1'b0, 1'b0, 80'h0},
        '{32'hffff_0000,    1'b0, 1'b0, 80'h0}
    };

    localparam logic [DATA_W-1:0] POW10 [DIGITS] = '{
        32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000,
        32'd10000000, 32'd100000000, 32'd1000000000
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_valid;
    logic                     i_stall;
    t_decimal                 dut_out;

    t_decimal pending_conversions [$];
    int       mismatches;
    int       n_sent;
    int       n_checked;
    int       n_negative;
    int       quiet_cycles;
    bit       sender_quiet;

    signed_binary_to_ascii_decimal i_dut (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_valid                   (i_valid),
        .o_stall                   (o_stall),
        .i_value                   (i_value),
        .o_valid                   (o_valid),
        .i_stall                   (i_stall),
        .o_is_negative             (dut_out.negative),
        .o_digit_ones              (dut_out.chars[0]),
        .o_digit_tens              (dut_out.chars[1]),
        .o_digit_hundreds          (dut_out.chars[2]),
        .o_digit_thousands         (dut_out.chars[3]),
        .o_digit_ten_thousands     (dut_out.chars[4]),
        .o_digit_hundred_thousands (dut_out.chars[5]),
        .o_digit_millions          (dut_out.chars[6]),
        .o_digit_ten_millions      (dut_out.chars[7]),
        .o_digit_hundred_millions  (dut_out.chars[8]),
        .o_digit_billions          (dut_out.chars[9])
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_decimal decimal_of(logic [DATA_W-1:0] v);
        t_decimal         res;
        logic [DATA_W:0]  mag;
        res.negative = v[DATA_W-1];
        mag = v[DATA_W-1] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
        for (int k = 0; k < DIGITS; k++) begin
            res.chars[k] = 6'd48 + CHAR_W'(mag % 10);
            mag = mag / 10;
        end
        return res;
    endfunction

    function automatic t_decimal decimal_from_text(logic negative, logic [79:0] text);
        t_decimal res;
        res.negative = negative;
        for (int k = 0; k < DIGITS; k++) begin
            res.chars[k] = text[8*k +: CHAR_W];
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4: v = $urandom_range(999);
            5: v = POW10[$urandom_range(DIGITS-1)] + DATA_W'($urandom_range(2)) - 32'd1;
            6: v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                     : 32'h7fff_ffff - $urandom_range(3);
            7: v = POW10[$urandom_range(DIGITS-1)] * $urandom_range(9);
            default: v = $urandom >> $urandom_range(31);
        endcase
        if ($urandom_range(2) == 0) begin
            v = -v;
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic offer(logic [DATA_W-1:0] v, t_decimal want);
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_stall);
        pending_conversions.push_back(want);
        n_sent++;
        if (v[DATA_W-1]) begin
            n_negative++;
        end
        while (!sender_quiet && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            i_value <= $urandom;
            @(posedge i_clk);
        end
    endtask

    // output side: random stall, one long hold, one stretch with no stall
    initial begin
        int  rx_cycle;
        bit  held;
        i_stall  = 1'b0;
        rx_cycle = 0;
        held     = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (!held && n_sent >= 300) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
            end
            if (rx_cycle > 15000 && rx_cycle < 25000) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 33);
            end
        end
    end

    always @(posedge i_clk) begin
        t_decimal want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_conversions.size() == 0) begin
                report_mismatch("results beyond transactions sent", n_checked + 1, n_sent);
            end else begin
                want = pending_conversions.pop_front();
                n_checked++;
                if (dut_out.negative !== want.negative) begin
                    report_mismatch("is_negative", dut_out.negative, want.negative);
                end
                for (int k = 0; k < DIGITS; k++) begin
                    if (dut_out.chars[k] !== want.chars[k]) begin
                        report_mismatch($sformatf("digit 10^%0d", k), dut_out.chars[k],
                                        want.chars[k]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCH_MAX) begin
            $display("watchdog: no transaction for %0d cycles", WATCH_MAX);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_value      = '0;
        n_sent       = 0;
        n_negative   = 0;
        sender_quiet = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_VECTORS; i++) begin
            offer(VECTORS[i].value,
                  VECTORS[i].typed ? decimal_from_text(VECTORS[i].negative, VECTORS[i].text)
                                   : decimal_of(VECTORS[i].value));
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            logic [DATA_W-1:0] v;
            sender_quiet = (i >= 700 && i < 1000);
            v = random_value();
            offer(v, decimal_of(v));
        end
        i_valid <= 1'b0;

        while (pending_conversions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_LEN) @(posedge i_clk);

        $display("converted %0d values (%0d negative), %0d results checked, %0d mismatches",
                 n_sent, n_negative, n_checked, mismatches);
        $display("covered both extremes, zero, powers of ten and a long output hold");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
